// ----- rtl/tesp_pkg.sv -----
// shared types and constants for the timed event segment player
`timescale 1ns / 1ps
package tesp_pkg;
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_HEADER = 3'd1;
	localparam logic [2:0] OP_EVENT  = 3'd2;
	localparam logic [2:0] OP_RETIRE = 3'd3;
	localparam logic [2:0] OP_HALT   = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_TYPE    = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	localparam logic [1:0] REG_TRACK_TYPE_KEY = 2'd0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_EV_RD,
		S_EV_CHK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // capture input request
		logic do_simple;  // execute header/event/retire/halt
		logic slot_rd;    // load scan pointer from read slot
		logic slot_next;  // advance scan pointer
		logic ev_first;   // set event index to zero
		logic ev_rd;      // read event pair
		logic ev_next;    // advance event index
		logic emit;       // emit mask of current event if changed
		logic out_load;   // load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic playing;
		logic slot_hit;
		logic slot_last;
		logic ev_hit;
		logic ev_last;
		logic out_busy;
	} stat_t;
endpackage

// ----- rtl/timed_event_segment_player_top.sv -----
// result valid after a header, event, retire, halt or idle tick request is taken and passes S_SLOT_RD and S_DONE
// a tick scans the slots in S_SLOT_CHK, then reads and checks event pairs in S_EV_RD and S_EV_CHK
// before S_DONE, one request at a time
// next request is taken the cycle after the result register loads
// asynchronous reset empties the ring, stops playback and clears the type key
`timescale 1ns / 1ps
module timed_event_segment_player_top #(
	parameter int QUEUE_SLOTS = 8,
	parameter int MAX_EVENTS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] now_time,
	input  logic [31:0] seg_start,
	input  logic [31:0] seg_end,
	input  logic [7:0]  seg_type,
	input  logic [31:0] event_stamp,
	input  logic [7:0]  event_mask,
	input  logic        last_event,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        mask_valid,
	output logic [7:0]  mask_out,
	output logic        retired
);
	import tesp_pkg::*;

	logic [7:0] key_q;
	cmd_t  cmd;
	stat_t st;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TRACK_TYPE_KEY) ? {24'd0, key_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_q <= '0;
		else if (psel && penable && pwrite && paddr == REG_TRACK_TYPE_KEY)
			key_q <= pwdata[7:0];
	end

	tesp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.st(st), .cmd(cmd)
	);

	tesp_dp #(.QUEUE_SLOTS(QUEUE_SLOTS), .MAX_EVENTS(MAX_EVENTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .type_key(key_q),
		.op(op), .now_time(now_time), .seg_start(seg_start), .seg_end(seg_end),
		.seg_type(seg_type), .event_stamp(event_stamp), .event_mask(event_mask),
		.last_event(last_event), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .mask_valid(mask_valid), .mask_out(mask_out),
		.retired(retired)
	);
endmodule

// ----- rtl/tesp_ctrl.sv -----
// controller state machine sequencing tick scans and simple requests
`timescale 1ns / 1ps
module tesp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tesp_pkg::stat_t st,
	output tesp_pkg::cmd_t  cmd
);
	import tesp_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SLOT_RD;
			S_SLOT_RD: begin
				// first visit after capture decides request kind
				if (!st.is_tick || !st.playing) state_d = S_DONE;
				else state_d = S_SLOT_CHK;
			end
			S_SLOT_CHK: begin
				if (st.slot_hit) state_d = S_EV_RD;
				else if (st.slot_last) state_d = S_DONE;
				else state_d = S_SLOT_CHK;
			end
			S_EV_RD: state_d = S_EV_CHK;
			S_EV_CHK: begin
				if (st.ev_hit || st.ev_last) state_d = S_DONE;
				else state_d = S_EV_RD;
			end
			S_DONE: if (!st.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.take = in_valid;
			S_SLOT_RD: begin
				cmd.do_simple = !st.is_tick;
				cmd.slot_rd = st.is_tick;
			end
			S_SLOT_CHK: begin
				cmd.ev_first = st.slot_hit;
				cmd.slot_next = !st.slot_hit;
			end
			S_EV_RD: cmd.ev_rd = 1'b1;
			S_EV_CHK: begin
				cmd.emit = st.ev_hit;
				cmd.ev_next = !st.ev_hit;
			end
			S_DONE: cmd.out_load = !st.out_busy;
			default: ;
		endcase
	end
endmodule

// ----- rtl/tesp_dp.sv -----
// datapath: slot tables, event memory, scan pointers and result register
`timescale 1ns / 1ps
module tesp_dp #(
	parameter int QUEUE_SLOTS = 8,
	parameter int MAX_EVENTS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tesp_pkg::cmd_t  cmd,
	output tesp_pkg::stat_t st,
	input  logic [7:0]      type_key,
	input  logic [2:0]      op,
	input  logic [31:0]     now_time,
	input  logic [31:0]     seg_start,
	input  logic [31:0]     seg_end,
	input  logic [7:0]      seg_type,
	input  logic [31:0]     event_stamp,
	input  logic [7:0]      event_mask,
	input  logic            last_event,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output logic            mask_valid,
	output logic [7:0]      mask_out,
	output logic            retired
);
	import tesp_pkg::*;

	localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int EW = $clog2(MAX_EVENTS);
	localparam int CW = $clog2(MAX_EVENTS + 1);
	localparam int AW = SW + EW;
	localparam int DEPTH = QUEUE_SLOTS << EW;

	// captured request
	logic [2:0]  op_q;
	logic [31:0] now_q, start_q, end_q, stamp_q;
	logic [7:0]  type_q, emask_q;
	logic        last_q;

	logic [31:0] slot_start_q [QUEUE_SLOTS];
	logic [31:0] slot_end_q [QUEUE_SLOTS];
	logic [CW-1:0] slot_cnt_q [QUEUE_SLOTS];
	logic [QUEUE_SLOTS-1:0] used_q;

	logic [SW-1:0] wslot_q, rslot_q, scan_q;
	logic [SW:0]   scan_left_q;
	logic          playing_q, loading_q;
	logic [7:0]    prev_q;
	logic [CW-1:0] load_cnt_q;

	// event memory, two banks so a stamp pair is read at once
	logic [31:0] stamp_mem [DEPTH];
	logic [31:0] stamp_b [DEPTH];
	logic [7:0]  mask_mem [DEPTH];
	logic [31:0] st_a_s1, st_b_s1;
	logic [7:0]  m_s1;

	// scan context
	logic [31:0]   seg_time_q;
	logic [CW-1:0] n_q;
	logic [EW-1:0] ev_q;
	logic [SW-1:0] hit_slot_q;

	// pending result
	logic [1:0] res_status_q;
	logic       res_mv_q, res_ret_q;
	logic [7:0] res_mask_q;

	function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s);
		if ({1'b0, s} == (SW+1)'(QUEUE_SLOTS - 1)) return '0;
		return s + 1'b1;
	endfunction

	logic [SW-1:0] wnext;
	logic          full;
	logic          load_room;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          ev_wr;
	logic [EW:0]   ev_idx1;

	assign wnext     = nxt(wslot_q);
	assign full      = used_q[wnext];
	assign load_room = load_cnt_q < CW'(MAX_EVENTS);
	assign wr_addr   = {wslot_q, load_cnt_q[EW-1:0]};
	assign rd_addr   = {hit_slot_q, ev_q};
	assign ev_wr     = cmd.do_simple && op_q == OP_EVENT && loading_q && load_room;
	assign ev_idx1   = {1'b0, ev_q} + 1'b1;

	assign st.is_tick   = (op_q == OP_TICK);
	assign st.playing   = playing_q;
	assign st.slot_hit  = used_q[scan_q] && slot_start_q[scan_q] <= now_q
		&& now_q < slot_end_q[scan_q];
	assign st.slot_last = (scan_left_q == (SW+1)'(1));
	// a segment needs at least one stamp pair before anything can match
	assign st.ev_hit    = (n_q > CW'(1)) && (st_a_s1 < seg_time_q) && (seg_time_q < st_b_s1);
	assign st.ev_last   = ({1'b0, ev_idx1} + 1'b1) >= (EW+2)'(n_q);
	assign st.out_busy  = out_valid && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= op; now_q <= now_time; start_q <= seg_start; end_q <= seg_end;
			type_q <= seg_type; stamp_q <= event_stamp; emask_q <= event_mask;
			last_q <= last_event;
		end
		if (ev_wr) begin
			stamp_mem[wr_addr] <= stamp_q;
			mask_mem[wr_addr]  <= emask_q;
			// second bank holds at each index the stamp of the entry at index+1
			if (load_cnt_q != '0) stamp_b[wr_addr - 1'b1] <= stamp_q;
		end
		if (cmd.ev_rd) begin
			st_a_s1 <= stamp_mem[rd_addr];
			st_b_s1 <= stamp_b[rd_addr];
			m_s1    <= mask_mem[rd_addr];
		end
		if (cmd.do_simple && op_q == OP_HEADER && !full && type_q == type_key) begin
			slot_start_q[wslot_q] <= start_q;
			slot_end_q[wslot_q]   <= end_q;
		end
		if (cmd.do_simple && op_q == OP_EVENT && loading_q && last_q)
			slot_cnt_q[wslot_q] <= load_room ? load_cnt_q + 1'b1 : load_cnt_q;
		if (cmd.ev_first) begin
			seg_time_q <= now_q - slot_start_q[scan_q];
			n_q        <= slot_cnt_q[scan_q];
			hit_slot_q <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0; wslot_q <= '0; rslot_q <= '0; scan_q <= '0;
			scan_left_q <= '0; playing_q <= 1'b0; loading_q <= 1'b0;
			prev_q <= '0; load_cnt_q <= '0; ev_q <= '0;
			res_status_q <= ST_OK; res_mv_q <= 1'b0; res_ret_q <= 1'b0;
			res_mask_q <= '0; out_valid <= 1'b0;
			status <= ST_OK; mask_valid <= 1'b0; mask_out <= '0; retired <= 1'b0;
		end else begin
			if (cmd.take) begin
				res_status_q <= ST_OK; res_mv_q <= 1'b0; res_ret_q <= 1'b0;
				res_mask_q <= '0;
			end
			if (cmd.slot_rd) begin
				scan_q <= rslot_q;
				scan_left_q <= (SW+1)'(QUEUE_SLOTS);
			end
			if (cmd.slot_next) begin
				scan_q <= nxt(scan_q);
				scan_left_q <= scan_left_q - 1'b1;
			end
			if (cmd.ev_first) ev_q <= '0;
			if (cmd.ev_next) ev_q <= ev_idx1[EW-1:0];
			if (cmd.emit && m_s1 != prev_q) begin
				prev_q <= m_s1; res_mv_q <= 1'b1; res_mask_q <= m_s1;
			end
			if (cmd.do_simple) begin
				case (op_q)
					OP_HEADER: begin
						loading_q <= 1'b0; load_cnt_q <= '0;
						if (full) res_status_q <= ST_FULL;
						else if (type_q != type_key) res_status_q <= ST_TYPE;
						else loading_q <= 1'b1;
					end
					OP_EVENT: begin
						if (!loading_q) res_status_q <= ST_DROPPED;
						else begin
							if (load_room) load_cnt_q <= load_cnt_q + 1'b1;
							else res_status_q <= ST_DROPPED;
							if (last_q) begin
								used_q[wslot_q] <= 1'b1; wslot_q <= wnext;
								playing_q <= 1'b1; loading_q <= 1'b0; load_cnt_q <= '0;
							end
						end
					end
					OP_RETIRE: begin
						if (used_q[rslot_q] && slot_end_q[rslot_q] < now_q) begin
							used_q[rslot_q] <= 1'b0; rslot_q <= nxt(rslot_q);
							res_ret_q <= 1'b1;
						end
					end
					OP_HALT: begin
						used_q <= '0; wslot_q <= '0; rslot_q <= '0; playing_q <= 1'b0;
						prev_q <= '0; loading_q <= 1'b0; load_cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1; status <= res_status_q; mask_valid <= res_mv_q;
				mask_out <= res_mask_q; retired <= res_ret_q;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
